// ===== design/fit_strategy_block_allocator_unit_macros.svh =====
// Assertion helpers for the fit-strategy block allocator.
`ifndef FIT_STRATEGY_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define FIT_STRATEGY_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define FSBA_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fsba check failed: same-cycle rule");

// Next-cycle implication, disabled while reset is low.
`define FSBA_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fsba check failed: next-cycle rule");

`endif

// ===== design/fsba_pkg.sv =====
package fsba_pkg;

    // Fixed field widths of the channels
    localparam int BLK_IDX_W  = 4;
    localparam int AMOUNT_W   = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STRATEGY      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 4'd1;

    // Item modes
    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;

    typedef enum logic [1:0] {
        STRAT_FIRST = 2'd0,
        STRAT_NEXT  = 2'd1,
        STRAT_BEST  = 2'd2,
        STRAT_WORST = 2'd3
    } t_strategy;

    typedef enum logic [1:0] {
        ST_LOADED = 2'd0,
        ST_GRANT  = 2'd1,
        ST_NOMEM  = 2'd2
    } t_status;

    typedef struct packed {
        logic                 mode;
        logic [BLK_IDX_W-1:0] block_index;
        logic [AMOUNT_W-1:0]  amount;
    } t_req;

    typedef struct packed {
        t_status              status;
        logic [BLK_IDX_W-1:0] granted_block;
        logic [AMOUNT_W-1:0]  remaining_after;
    } t_rsp;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] wr_data;
    } t_cfg;

endpackage

// ===== design/fsba_if.sv =====
// Request channel: load or allocation items
interface fsba_req_if;
    import fsba_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Response channel: one result per item
interface fsba_rsp_if;
    import fsba_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Register write channel
interface fsba_cfg_if;
    import fsba_pkg::*;
    logic valid;
    logic ready;
    t_cfg data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/fsba_ram.sv =====
module fsba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/fit_strategy_block_allocator_unit.sv =====
// Fit-strategy block allocator.
// i_req carries items: mode 0 loads a block size (clears the failure flag and
// rewinds the next-fit pointer), mode 1 requests an allocation. o_rsp returns
// exactly one beat per item: status, chosen block and its remaining size.
// i_cfg writes the strategy (index 0) and the number of searched blocks
// (index 1); it is always ready. It must be written only while the block is
// idle; the block itself does not enforce this. A load passes the done state
// and writes its result to the output register as it returns to idle, where
// the next item can be taken. A request scans the block sizes through the
// single read port of the size memory, one block per cycle, with one
// subtract/compare unit, and stops early when first or next fit hits; a
// request that fails at once goes straight to the done state like a load.
// i_req is ready only while idle.
// A finished result waits in the output register; the next item is accepted
// meanwhile and its result is held back until the receiver takes the beat.
// Reset clears the strategy to first fit, the block count to 16, the pointer
// and the failure flag; block sizes are undefined until loaded, and no
// clearing pass runs.
module fit_strategy_block_allocator_unit #(
    parameter int MAX_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fsba_req_if.sink     i_req,
    fsba_rsp_if.source   o_rsp,
    fsba_cfg_if.sink     i_cfg
);

    import fsba_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                r_state;
    t_strategy             r_strategy;
    logic [4:0]            r_blocks;
    logic [IDX_W-1:0]      r_rover;
    logic                  r_run_failed;
    logic                  r_out_valid;
    t_rsp                  r_out;

    // Per-item working registers
    logic                  r_is_load;
    logic                  r_wr;
    logic [SIZE_BITS-1:0]  r_req;
    logic [CNT_W-1:0]      r_n;
    logic [CNT_W-1:0]      r_issued;
    logic [IDX_W-1:0]      r_addr;
    logic                  r_pend;
    logic [IDX_W-1:0]      r_pend_addr;
    logic                  r_found;
    logic [IDX_W-1:0]      r_pick;
    logic [SIZE_BITS-1:0]  r_left;

    logic                  n_found;
    logic [IDX_W-1:0]      n_pick;
    logic [SIZE_BITS-1:0]  n_left;

    logic                  req_fire;
    logic                  cfg_fire;
    logic                  done_fire;
    logic                  sticky;
    logic [8:0]            blocks_wide;
    logic [CNT_W-1:0]      active_n;
    logic [IDX_W-1:0]      start_pos;
    logic [47:0]           amt_wide;
    logic [SIZE_BITS-1:0]  amt;
    logic [11:0]           idx_wide;
    logic                  idx_ok;
    logic [IDX_W-1:0]      rd_addr;
    logic [SIZE_BITS-1:0]  rd_data;
    logic [SIZE_BITS:0]    diff_full;
    logic [SIZE_BITS-1:0]  diff;
    logic                  fits;
    logic                  better;
    logic                  take;
    logic                  more;
    logic [11:0]           pick_wide;
    logic [47:0]           left_wide;
    logic [IDX_W-1:0]      pick_next;

    // Cyclic successor of a block position within the searched range
    function automatic logic [IDX_W-1:0] next_pos(input logic [IDX_W-1:0] pos,
                                                   input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] p1;
        p1 = CNT_W'(pos) + CNT_W'(1);
        return (p1 == cnt) ? '0 : p1[IDX_W-1:0];
    endfunction

    assign req_fire  = i_req.valid && i_req.ready;
    assign cfg_fire  = i_cfg.valid && i_cfg.ready;
    assign done_fire = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);
    assign sticky    = (r_strategy == STRAT_FIRST) || (r_strategy == STRAT_NEXT);

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    // Searched block count, clipped to the memory depth
    assign blocks_wide = {4'd0, r_blocks};
    assign active_n    = (blocks_wide > 9'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                        : CNT_W'(blocks_wide);
    assign start_pos   = ((r_strategy == STRAT_NEXT) && (CNT_W'(r_rover) < active_n))
                         ? r_rover : '0;

    // Input field conversion to the internal widths
    assign amt_wide = {32'd0, i_req.data.amount};
    assign amt      = amt_wide[SIZE_BITS-1:0];
    assign idx_wide = {8'd0, i_req.data.block_index};
    assign idx_ok   = ({5'd0, i_req.data.block_index} < 9'(MAX_BLOCKS));

    // First read is issued while accepting; then the scan pointer drives it
    assign rd_addr = (r_state == S_IDLE) ? start_pos : r_addr;

    fsba_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (MAX_BLOCKS)
    ) u_sizes (
        .i_clk   (i_clk),
        .i_we    (done_fire && r_wr),
        .i_waddr (r_pick),
        .i_wdata (r_left),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Shared subtract/compare unit: leftover and fit test of the block read back
    assign diff_full = {1'b0, rd_data} - {1'b0, r_req};
    assign diff      = diff_full[SIZE_BITS-1:0];
    assign fits      = !diff_full[SIZE_BITS];

    always_comb begin
        case (r_strategy)
            STRAT_BEST:  better = !r_found || (diff < r_left);
            STRAT_WORST: better = !r_found || (diff > r_left);
            default:     better = 1'b1;
        endcase
    end

    assign take    = r_pend && fits && better;
    assign n_found = r_found || take;
    assign n_pick  = take ? r_pend_addr : r_pick;
    assign n_left  = take ? diff : r_left;
    assign more    = (r_issued != r_n);

    // Result field conversion and next-fit pointer after a grant
    assign pick_wide = 12'(r_pick);
    assign left_wide = 48'(r_left);
    assign pick_next = next_pos(r_pick, r_n);

    // Sequencer, state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_strategy   <= STRAT_FIRST;
            r_blocks     <= 5'd16;
            r_rover      <= '0;
            r_run_failed <= 1'b0;
            r_out_valid  <= 1'b0;
            r_pend       <= 1'b0;
        end else begin
            // register writes
            if (cfg_fire) begin
                case (i_cfg.data.reg_index)
                    REG_STRATEGY:      r_strategy <= t_strategy'(i_cfg.data.wr_data[1:0]);
                    REG_BLOCKS_IN_USE: r_blocks   <= i_cfg.data.wr_data[4:0];
                    default:           ;
                endcase
            end

            // output register: filled on finish, freed when the beat is taken
            if (done_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (req_fire) begin
                        r_is_load <= (i_req.data.mode == MODE_LOAD);
                        r_found   <= 1'b0;
                        if (i_req.data.mode == MODE_LOAD) begin
                            r_wr         <= idx_ok;
                            r_pick       <= idx_wide[IDX_W-1:0];
                            r_left       <= idx_ok ? amt : '0;
                            r_run_failed <= 1'b0;
                            r_rover      <= '0;
                            r_state      <= S_DONE;
                        end else begin
                            r_req <= amt;
                            r_n   <= active_n;
                            if ((sticky && r_run_failed) || (active_n == '0)) begin
                                r_wr    <= 1'b0;
                                r_state <= S_DONE;
                            end else begin
                                r_pend      <= 1'b1;
                                r_pend_addr <= start_pos;
                                r_addr      <= next_pos(start_pos, active_n);
                                r_issued    <= CNT_W'(1);
                                r_state     <= S_SCAN;
                            end
                        end
                    end
                end

                S_SCAN: begin
                    r_found <= n_found;
                    r_pick  <= n_pick;
                    r_left  <= n_left;
                    if ((take && sticky) || !more) begin
                        r_wr    <= n_found;
                        r_pend  <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_pend      <= 1'b1;
                        r_pend_addr <= r_addr;
                        r_addr      <= next_pos(r_addr, r_n);
                        r_issued    <= r_issued + CNT_W'(1);
                    end
                end

                S_DONE: begin
                    if (done_fire) begin
                        if (r_is_load) begin
                            r_out.status          <= ST_LOADED;
                            r_out.granted_block   <= '0;
                            r_out.remaining_after <= left_wide[AMOUNT_W-1:0];
                        end else if (r_found) begin
                            r_out.status          <= ST_GRANT;
                            r_out.granted_block   <= pick_wide[BLK_IDX_W-1:0];
                            r_out.remaining_after <= left_wide[AMOUNT_W-1:0];
                            if (r_strategy == STRAT_NEXT) begin
                                r_rover <= pick_next;
                            end
                        end else begin
                            r_out.status          <= ST_NOMEM;
                            r_out.granted_block   <= '0;
                            r_out.remaining_after <= '0;
                            if (sticky) begin
                                r_run_failed <= 1'b1;
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== design/fsba_chk.sv =====
`include "fit_strategy_block_allocator_unit_macros.svh"

module fsba_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_req_valid,
    input logic           i_req_ready,
    input logic           i_req_mode,
    input logic           i_rsp_valid,
    input logic           i_rsp_ready,
    input fsba_pkg::t_rsp i_rsp_data
);

    import fsba_pkg::*;

    // A stalled result beat holds its value
    `FSBA_ASSERT_NXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_data))

    // Only a grant names a block
    `FSBA_ASSERT_IMP(a_block_only_on_grant, i_clk, i_rst_n, i_rsp_valid && (i_rsp_data.status != ST_GRANT), i_rsp_data.granted_block == '0)

    // A refused request reports no remaining size
    `FSBA_ASSERT_IMP(a_nomem_zero, i_clk, i_rst_n, i_rsp_valid && (i_rsp_data.status == ST_NOMEM), i_rsp_data.remaining_after == '0)

    // The block is busy in the cycle after it takes a request
    `FSBA_ASSERT_NXT(a_busy_after_req, i_clk, i_rst_n, i_req_valid && i_req_ready && (i_req_mode == MODE_REQUEST), !i_req_ready)

endmodule

bind fit_strategy_block_allocator_unit fsba_chk u_fsba_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_req_mode  (i_req.data.mode),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);
